// ===== sv/atrp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package atrp_pkg;

    localparam int DEF_SAMPLE_BITS  = 10;
    localparam int DEF_CORDIC_STEPS = 16;

    // Angles are signed radians with 24 fractional bits.
    localparam int ANG_W     = 29;
    localparam int FRAC_BITS = 24;
    localparam logic signed [ANG_W-1:0] Q_HALF_PI = 29'sd26353589;
    localparam logic signed [ANG_W-1:0] Q_PI      = 29'sd52707179;

    localparam int MAP_SCALE      = 1000;
    localparam int MAP_OFFSET     = 500;
    localparam int PITCH_PRESCALE = 16;

    localparam int RST_X_LOW  = 338;
    localparam int RST_X_HIGH = 680;
    localparam int RST_Y_LOW  = 328;
    localparam int RST_Y_HIGH = 680;
    localparam int RST_Z_LOW  = 330;
    localparam int RST_Z_HIGH = 730;

    localparam int REG_IDX_W = 3;
    typedef enum logic [REG_IDX_W-1:0] {
        REG_X_LOW  = 3'd0,
        REG_X_HIGH = 3'd1,
        REG_Y_LOW  = 3'd2,
        REG_Y_HIGH = 3'd3,
        REG_Z_LOW  = 3'd4,
        REG_Z_HIGH = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic valid;
        logic bad;
    } t_ctl;

    // Square root: the operand is normalized below 2^62, the root has 31 bits.
    localparam int SQ_IN_W   = 62;
    localparam int SQ_OUT_W  = 31;
    localparam int SHIFT_MAX = 16;

    // Degrees = angle * 573 / (10 * 2^24); the divide by ten is a reciprocal multiply.
    localparam int DEG_W       = 12;
    localparam int DEG_MUL     = 573;
    localparam int DEG_MUL_W   = 11;
    localparam int DIV10_MUL   = 52429;
    localparam int DIV10_SHIFT = 19;
    localparam int ROLL_LIM    = 90;
    localparam int PITCH_LIM   = 180;

    function automatic logic signed [ANG_W-1:0] atan_entry(input int unsigned idx);
        logic signed [ANG_W-1:0] v;
        case (idx)
            0:       v = 29'sd13176795;
            1:       v = 29'sd7778716;
            2:       v = 29'sd4110060;
            3:       v = 29'sd2086331;
            4:       v = 29'sd1047214;
            5:       v = 29'sd524117;
            6:       v = 29'sd262123;
            7:       v = 29'sd131069;
            8:       v = 29'sd65536;
            9:       v = 29'sd32768;
            10:      v = 29'sd16384;
            11:      v = 29'sd8192;
            12:      v = 29'sd4096;
            13:      v = 29'sd2048;
            14:      v = 29'sd1024;
            15:      v = 29'sd512;
            16:      v = 29'sd256;
            17:      v = 29'sd128;
            18:      v = 29'sd64;
            19:      v = 29'sd32;
            20:      v = 29'sd16;
            21:      v = 29'sd8;
            22:      v = 29'sd4;
            23:      v = 29'sd2;
            24:      v = 29'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== sv/atrp_div_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
module atrp_div_cell import atrp_pkg::*; #(
    parameter int SB = DEF_SAMPLE_BITS,
    parameter int NB = DEF_SAMPLE_BITS + 10
) (
    input  wire logic          i_clk,
    input  wire logic [SB-1:0] i_den,
    input  wire logic [SB-1:0] i_rem,
    input  wire logic [NB-1:0] i_dvd,
    input  wire logic [NB-1:0] i_quo,
    input  wire logic          i_neg,
    output logic      [SB-1:0] o_rem,
    output logic      [NB-1:0] o_dvd,
    output logic      [NB-1:0] o_quo,
    output logic               o_neg
);
    logic [SB:0] trial;
    logic [SB:0] diff;
    logic        take;

    assign trial = {i_rem, i_dvd[NB-1]};
    assign take  = trial >= {1'b0, i_den};
    assign diff  = trial - {1'b0, i_den};

    always_ff @(posedge i_clk) begin
        o_rem <= take ? diff[SB-1:0] : trial[SB-1:0];
        o_dvd <= {i_dvd[NB-2:0], 1'b0};
        o_quo <= {i_quo[NB-2:0], take};
        o_neg <= i_neg;
    end
endmodule
`default_nettype wire

// ===== sv/atrp_map.sv =====
`timescale 1ns / 1ps
`default_nettype none
module atrp_map import atrp_pkg::*; #(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_start,
    input  wire logic [2:0][SAMPLE_BITS-1:0]            i_raw,
    input  wire logic [2:0][SAMPLE_BITS-1:0]            i_lo,
    input  wire logic [2:0][SAMPLE_BITS-1:0]            i_hi,
    output logic      [2:0][SAMPLE_BITS+10:0]           o_m,
    output t_ctl                                        o_ctl
);
    localparam int SB = SAMPLE_BITS;
    localparam int NB = SAMPLE_BITS + 10;
    localparam int MW = SAMPLE_BITS + 11;
    localparam logic signed [MW-1:0] OFFS = MW'(MAP_OFFSET);

    logic [SB-1:0] s_rem [3][NB+1];
    logic [NB-1:0] s_dvd [3][NB+1];
    logic [NB-1:0] s_quo [3][NB+1];
    logic          s_neg [3][NB+1];
    logic [SB-1:0] w_den [3];
    logic          w_bad;
    t_ctl          r_ctl [NB+2];

    assign w_bad = (i_hi[0] <= i_lo[0]) || (i_hi[1] <= i_lo[1]) || (i_hi[2] <= i_lo[2]);

    for (genvar a = 0; a < 3; a++) begin : g_axis
        logic signed [SB:0]   diff;
        logic        [SB-1:0] mag;
        logic        [NB-1:0] r_dvd;
        logic                 r_neg;
        logic signed [MW-1:0] qs;
        logic signed [MW-1:0] n_m;
        logic        [MW-1:0] r_m;

        assign w_den[a] = i_hi[a] - i_lo[a];
        assign diff = $signed({1'b0, i_raw[a]}) - $signed({1'b0, i_lo[a]});
        assign mag  = diff[SB] ? SB'(-diff) : diff[SB-1:0];

        always_ff @(posedge i_clk) begin
            r_dvd <= NB'(mag) * NB'(MAP_SCALE);
            r_neg <= diff[SB];
        end

        assign s_rem[a][0] = '0;
        assign s_quo[a][0] = '0;
        assign s_dvd[a][0] = r_dvd;
        assign s_neg[a][0] = r_neg;

        for (genvar k = 0; k < NB; k++) begin : g_step
            atrp_div_cell #(.SB(SB), .NB(NB)) u_cell (
                .i_clk (i_clk),
                .i_den (w_den[a]),
                .i_rem (s_rem[a][k]),
                .i_dvd (s_dvd[a][k]),
                .i_quo (s_quo[a][k]),
                .i_neg (s_neg[a][k]),
                .o_rem (s_rem[a][k+1]),
                .o_dvd (s_dvd[a][k+1]),
                .o_quo (s_quo[a][k+1]),
                .o_neg (s_neg[a][k+1])
            );
        end

        // Truncation toward zero: divide the magnitude, then restore the sign.
        assign qs  = $signed({1'b0, s_quo[a][NB]});
        assign n_m = (s_neg[a][NB] ? -qs : qs) - OFFS;

        always_ff @(posedge i_clk) begin
            r_m <= n_m;
        end
        assign o_m[a] = r_m;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NB + 2; i++) begin
                r_ctl[i] <= '0;
            end
        end else begin
            r_ctl[0] <= '{valid: i_start, bad: w_bad};
            for (int i = 1; i < NB + 2; i++) begin
                r_ctl[i] <= r_ctl[i-1];
            end
        end
    end

    assign o_ctl = r_ctl[NB+1];
endmodule
`default_nettype wire

// ===== sv/atrp_sqrt_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
module atrp_sqrt_cell import atrp_pkg::*; #(
    parameter int BIT    = 0,
    parameter int SIDE_W = 8
) (
    input  wire logic              i_clk,
    input  wire logic [SQ_IN_W-1:0] i_v,
    input  wire logic [SQ_OUT_W+1:0] i_rem,
    input  wire logic [SQ_OUT_W-1:0] i_root,
    input  wire logic [SIDE_W-1:0] i_side,
    output logic      [SQ_IN_W-1:0] o_v,
    output logic      [SQ_OUT_W+1:0] o_rem,
    output logic      [SQ_OUT_W-1:0] o_root,
    output logic      [SIDE_W-1:0] o_side
);
    logic [SQ_OUT_W+3:0] cur;
    logic [SQ_OUT_W+3:0] trial;
    logic [SQ_OUT_W+3:0] diff;
    logic                take;

    // One root bit per cell: bring down two operand bits, try root*4+1.
    assign cur   = {i_rem, i_v[2*BIT+1 -: 2]};
    assign trial = (SQ_OUT_W+4)'({i_root, 2'b01});
    assign take  = cur >= trial;
    assign diff  = cur - trial;

    always_ff @(posedge i_clk) begin
        o_v    <= i_v;
        o_rem  <= take ? diff[SQ_OUT_W+1:0] : cur[SQ_OUT_W+1:0];
        o_root <= {i_root[SQ_OUT_W-2:0], take};
        o_side <= i_side;
    end
endmodule
`default_nettype wire

// ===== sv/atrp_cordic_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
module atrp_cordic_cell import atrp_pkg::*; #(
    parameter int W   = 40,
    parameter int IDX = 0
) (
    input  wire logic                    i_clk,
    input  wire logic signed [W-1:0]     i_x,
    input  wire logic signed [W-1:0]     i_y,
    input  wire logic signed [ANG_W-1:0] i_acc,
    input  wire logic                    i_fix,
    input  wire logic signed [ANG_W-1:0] i_fix_ang,
    output logic      signed [W-1:0]     o_x,
    output logic      signed [W-1:0]     o_y,
    output logic      signed [ANG_W-1:0] o_acc,
    output logic                         o_fix,
    output logic      signed [ANG_W-1:0] o_fix_ang
);
    localparam logic signed [ANG_W-1:0] STEP_ANG = atan_entry(IDX);

    logic signed [W-1:0] xs;
    logic signed [W-1:0] ys;

    assign xs = i_x >>> IDX;
    assign ys = i_y >>> IDX;

    always_ff @(posedge i_clk) begin
        if (!i_y[W-1]) begin
            o_x   <= i_x + ys;
            o_y   <= i_y - xs;
            o_acc <= i_acc + STEP_ANG;
        end else begin
            o_x   <= i_x - ys;
            o_y   <= i_y + xs;
            o_acc <= i_acc - STEP_ANG;
        end
        o_fix     <= i_fix;
        o_fix_ang <= i_fix_ang;
    end
endmodule
`default_nettype wire

// ===== sv/atrp_cordic.sv =====
`timescale 1ns / 1ps
`default_nettype none
module atrp_cordic import atrp_pkg::*; #(
    parameter int W     = 40,
    parameter int STEPS = DEF_CORDIC_STEPS
) (
    input  wire logic                    i_clk,
    input  wire logic signed [W-1:0]     i_y,
    input  wire logic signed [W-1:0]     i_x,
    output logic      signed [DEG_W-1:0] o_deg
);
    localparam int PW = ANG_W + DEG_MUL_W;
    localparam logic signed [DEG_MUL_W-1:0] MUL_C = DEG_MUL_W'(DEG_MUL);

    logic signed [W-1:0]     s_x   [STEPS+1];
    logic signed [W-1:0]     s_y   [STEPS+1];
    logic signed [ANG_W-1:0] s_acc [STEPS+1];
    logic                    s_fix [STEPS+1];
    logic signed [ANG_W-1:0] s_fang[STEPS+1];

    logic                    x_zero;
    logic                    y_zero;
    logic signed [ANG_W-1:0] n_fang;
    logic signed [W-1:0]     n_x;
    logic signed [W-1:0]     n_y;
    logic signed [ANG_W-1:0] n_acc;

    logic signed [W-1:0]     r_x;
    logic signed [W-1:0]     r_y;
    logic signed [ANG_W-1:0] r_acc;
    logic                    r_fix;
    logic signed [ANG_W-1:0] r_fang;

    logic signed [ANG_W-1:0] w_ang;
    logic signed [PW-1:0]    r_prod;
    logic        [PW-1:0]    w_mag;
    logic        [31:0]      r_q;
    logic                    r_neg;
    logic signed [DEG_W-1:0] w_d;

    assign x_zero = (i_x == '0);
    assign y_zero = (i_y == '0);

    // Axis cases give exact angles and bypass the iterations.
    always_comb begin
        if (x_zero) begin
            n_fang = (!i_y[W-1] && !y_zero) ? Q_HALF_PI : (i_y[W-1] ? -Q_HALF_PI : '0);
        end else begin
            n_fang = i_x[W-1] ? Q_PI : '0;
        end
        if (i_x[W-1]) begin
            if (!i_y[W-1]) begin
                n_x   = i_y;
                n_y   = -i_x;
                n_acc = Q_HALF_PI;
            end else begin
                n_x   = -i_y;
                n_y   = i_x;
                n_acc = -Q_HALF_PI;
            end
        end else begin
            n_x   = i_x;
            n_y   = i_y;
            n_acc = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x    <= n_x;
        r_y    <= n_y;
        r_acc  <= n_acc;
        r_fix  <= x_zero || y_zero;
        r_fang <= n_fang;
    end

    assign s_x[0]    = r_x;
    assign s_y[0]    = r_y;
    assign s_acc[0]  = r_acc;
    assign s_fix[0]  = r_fix;
    assign s_fang[0] = r_fang;

    for (genvar i = 0; i < STEPS; i++) begin : g_step
        atrp_cordic_cell #(.W(W), .IDX(i)) u_cell (
            .i_clk     (i_clk),
            .i_x       (s_x[i]),
            .i_y       (s_y[i]),
            .i_acc     (s_acc[i]),
            .i_fix     (s_fix[i]),
            .i_fix_ang (s_fang[i]),
            .o_x       (s_x[i+1]),
            .o_y       (s_y[i+1]),
            .o_acc     (s_acc[i+1]),
            .o_fix     (s_fix[i+1]),
            .o_fix_ang (s_fang[i+1])
        );
    end

    assign w_ang = s_fix[STEPS] ? s_fang[STEPS] : s_acc[STEPS];
    assign w_mag = r_prod[PW-1] ? PW'(-r_prod) : PW'(r_prod);
    assign w_d   = $signed({1'b0, r_q[DIV10_SHIFT +: DEG_W-1]});

    always_ff @(posedge i_clk) begin
        r_prod <= w_ang * MUL_C;
        r_q    <= 32'(w_mag[PW-1:FRAC_BITS]) * 32'(DIV10_MUL);
        r_neg  <= r_prod[PW-1];
        o_deg  <= r_neg ? -w_d : w_d;
    end
endmodule
`default_nettype wire

// ===== sv/accel_tilt_roll_pitch_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Tilt from one raw three-axis accelerometer word: each axis is mapped to -500..500
// through its calibrated low/high span, then pitch = atan2(y, z) and
// roll = atan2(-x, sqrt(y^2 + z^2)) come out in signed whole degrees, truncated
// toward zero. The block is fully pipelined: a word is taken on every cycle
// (o_busy stays low), and its result shows on o_done for one cycle. The path is
// set by the per-axis divider chain (SAMPLE_BITS + 10 cells), the 31-cell square
// root chain and the CORDIC chain of CORDIC_STEPS cells. Results cannot be held
// off, so the receiver must take every o_done word. When some axis has high not
// above low, o_bad_calibration is set and both angles are zero. Calibration
// registers may only be written while no word is in flight.
module accel_tilt_roll_pitch_core import atrp_pkg::*; #(
    parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS,
    parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_start,
    output logic                        o_busy,
    input  wire logic [SAMPLE_BITS-1:0] i_accel_x,
    input  wire logic [SAMPLE_BITS-1:0] i_accel_y,
    input  wire logic [SAMPLE_BITS-1:0] i_accel_z,
    input  wire logic                   i_cfg_we,
    input  wire logic [REG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [SAMPLE_BITS-1:0] i_cfg_data,
    output logic                        o_done,
    output logic signed [7:0]           o_roll_deg,
    output logic signed [8:0]           o_pitch_deg,
    output logic                        o_bad_calibration
);
    localparam int SB     = SAMPLE_BITS;
    localparam int MW     = SAMPLE_BITS + 11;
    localparam int CW     = MW + 18;
    localparam int PRE_D  = 4;
    localparam int PIPE_D = PRE_D + SQ_OUT_W;
    localparam int CTL_D  = PIPE_D + CORDIC_STEPS + 4;
    localparam logic signed [DEG_W-1:0] ROLL_MAX  = DEG_W'(ROLL_LIM);
    localparam logic signed [DEG_W-1:0] PITCH_MAX = DEG_W'(PITCH_LIM);

    logic [SB-1:0] r_x_low, r_x_high, r_y_low, r_y_high, r_z_low, r_z_high;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_low  <= SB'(RST_X_LOW);
            r_x_high <= SB'(RST_X_HIGH);
            r_y_low  <= SB'(RST_Y_LOW);
            r_y_high <= SB'(RST_Y_HIGH);
            r_z_low  <= SB'(RST_Z_LOW);
            r_z_high <= SB'(RST_Z_HIGH);
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_X_LOW:  r_x_low  <= i_cfg_data;
                REG_X_HIGH: r_x_high <= i_cfg_data;
                REG_Y_LOW:  r_y_low  <= i_cfg_data;
                REG_Y_HIGH: r_y_high <= i_cfg_data;
                REG_Z_LOW:  r_z_low  <= i_cfg_data;
                REG_Z_HIGH: r_z_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_busy = 1'b0;

    logic [2:0][MW-1:0] w_m;
    t_ctl               w_ctl;

    atrp_map #(.SAMPLE_BITS(SB)) u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_raw   ({i_accel_z, i_accel_y, i_accel_x}),
        .i_lo    ({r_z_low, r_y_low, r_x_low}),
        .i_hi    ({r_z_high, r_y_high, r_x_high}),
        .o_m     (w_m),
        .o_ctl   (w_ctl)
    );

    // Roll radius: square, sum, pick the normalizing shift, then square root.
    logic signed [2*MW-1:0] r_sqy, r_sqz;
    logic        [MW-1:0]   r_mx1, r_mx2, r_mx3;
    logic        [2*MW-1:0] r_s, r_s3;
    logic        [63:0]     w_s64;
    logic [SHIFT_MAX-1:0]   w_flags, r_flags;
    logic [4:0]             w_sh;
    logic [SQ_IN_W-1:0]     r_v;
    logic signed [CW-1:0]   r_xs;

    assign w_s64 = 64'(r_s);
    for (genvar k = 1; k <= SHIFT_MAX; k++) begin : g_flag
        assign w_flags[k-1] = (w_s64[63:62-2*k] == '0);
    end
    // The flags are monotone, so their count is the largest shift that fits.
    assign w_sh = 5'($countones(r_flags));

    always_ff @(posedge i_clk) begin
        r_sqy   <= $signed(w_m[1]) * $signed(w_m[1]);
        r_sqz   <= $signed(w_m[2]) * $signed(w_m[2]);
        r_mx1   <= w_m[0];
        r_s     <= $unsigned(r_sqy + r_sqz);
        r_mx2   <= r_mx1;
        r_flags <= w_flags;
        r_s3    <= r_s;
        r_mx3   <= r_mx2;
        r_v     <= SQ_IN_W'(64'(r_s3) << {w_sh, 1'b0});
        r_xs    <= -(CW'($signed(r_mx3)) <<< w_sh);
    end

    logic [SQ_IN_W-1:0]  s_v    [SQ_OUT_W+1];
    logic [SQ_OUT_W+1:0] s_rem  [SQ_OUT_W+1];
    logic [SQ_OUT_W-1:0] s_root [SQ_OUT_W+1];
    logic [CW-1:0]       s_side [SQ_OUT_W+1];

    assign s_v[0]    = r_v;
    assign s_rem[0]  = '0;
    assign s_root[0] = '0;
    assign s_side[0] = r_xs;

    for (genvar j = 0; j < SQ_OUT_W; j++) begin : g_sqrt
        atrp_sqrt_cell #(.BIT(SQ_OUT_W-1-j), .SIDE_W(CW)) u_cell (
            .i_clk  (i_clk),
            .i_v    (s_v[j]),
            .i_rem  (s_rem[j]),
            .i_root (s_root[j]),
            .i_side (s_side[j]),
            .o_v    (s_v[j+1]),
            .o_rem  (s_rem[j+1]),
            .o_root (s_root[j+1]),
            .o_side (s_side[j+1])
        );
    end

    // Pitch operands wait for the roll radius so both angle chains run side by side.
    logic [MW-1:0] r_pdy [PIPE_D];
    logic [MW-1:0] r_pdz [PIPE_D];

    always_ff @(posedge i_clk) begin
        r_pdy[0] <= w_m[1];
        r_pdz[0] <= w_m[2];
        for (int i = 1; i < PIPE_D; i++) begin
            r_pdy[i] <= r_pdy[i-1];
            r_pdz[i] <= r_pdz[i-1];
        end
    end

    logic signed [DEG_W-1:0] w_pdeg, w_rdeg;

    atrp_cordic #(.W(CW), .STEPS(CORDIC_STEPS)) u_pitch (
        .i_clk (i_clk),
        .i_y   (CW'($signed(r_pdy[PIPE_D-1])) <<< PITCH_PRESCALE),
        .i_x   (CW'($signed(r_pdz[PIPE_D-1])) <<< PITCH_PRESCALE),
        .o_deg (w_pdeg)
    );

    atrp_cordic #(.W(CW), .STEPS(CORDIC_STEPS)) u_roll (
        .i_clk (i_clk),
        .i_y   ($signed(s_side[SQ_OUT_W])),
        .i_x   ($signed(CW'(s_root[SQ_OUT_W]))),
        .o_deg (w_rdeg)
    );

    t_ctl r_cdl [CTL_D];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CTL_D; i++) begin
                r_cdl[i] <= '0;
            end
        end else begin
            r_cdl[0] <= w_ctl;
            for (int i = 1; i < CTL_D; i++) begin
                r_cdl[i] <= r_cdl[i-1];
            end
        end
    end

    logic signed [DEG_W-1:0] w_rsat, w_psat;

    always_comb begin
        if (w_rdeg > ROLL_MAX) begin
            w_rsat = ROLL_MAX;
        end else if (w_rdeg < -ROLL_MAX) begin
            w_rsat = -ROLL_MAX;
        end else begin
            w_rsat = w_rdeg;
        end
        if (w_pdeg > PITCH_MAX) begin
            w_psat = PITCH_MAX;
        end else if (w_pdeg < -PITCH_MAX) begin
            w_psat = -PITCH_MAX;
        end else begin
            w_psat = w_pdeg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= r_cdl[CTL_D-1].valid;
        end
        o_bad_calibration <= r_cdl[CTL_D-1].bad;
        o_roll_deg        <= r_cdl[CTL_D-1].bad ? '0 : 8'(w_rsat);
        o_pitch_deg       <= r_cdl[CTL_D-1].bad ? '0 : 9'(w_psat);
    end

`ifndef ASSERT_OFF
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_bad_calibration |-> o_roll_deg == '0 && o_pitch_deg == '0)
        else $error("angles not zero on a bad calibration word");

    a_roll_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_roll_deg <= 8'sd90 && o_roll_deg >= -8'sd90)
        else $error("roll out of range");

    a_pitch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_pitch_deg <= 9'sd180 && o_pitch_deg >= -9'sd180)
        else $error("pitch out of range");

    a_sqrt_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cdl[PIPE_D-1].valid |->
            s_rem[SQ_OUT_W] <= (SQ_OUT_W+2)'({s_root[SQ_OUT_W], 1'b0}))
        else $error("square root remainder exceeds twice the root");
`endif
endmodule
`default_nettype wire
